// ===== rtl/hpe_pkg.sv =====
// Shared types and constants for the Horner polynomial evaluator.
// Used by hpe_cell and horner_polynomial_evaluator_unit; no dependencies.
`timescale 1ns / 1ps

package hpe_pkg;

   localparam int DATA_W      = 32;
   localparam int WIDE_W      = 2 * DATA_W;
   localparam int COUNT_W     = 3;
   localparam int CSR_INDEX_W = 3;

   localparam int DEF_MAX_COEFS = 7;
   localparam int DEF_FRAC_BITS = 16;

   // register map
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_BASE  = 3'd1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd1;

   // saturation bounds in the wide adder domain
   localparam logic signed [WIDE_W-1:0] WIDE_MAX =
      {{(DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] WIDE_MIN =
      {{(DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

   // partial result travelling along the chain
   typedef struct packed {
      logic                     valid;
      logic                     sat;
      logic signed [DATA_W-1:0] value;
   } hpe_tok_type;

endpackage

// ===== rtl/hpe_cell.sv =====
// One Horner step: registered multiply by x, then floor shift, add and saturate.
// Depends on hpe_pkg.
`timescale 1ns / 1ps

module hpe_cell #(
   parameter int FRAC_BITS = hpe_pkg::DEF_FRAC_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  logic signed [hpe_pkg::DATA_W-1:0]        x_value,
   input  logic signed [hpe_pkg::DATA_W-1:0]        coef,
   input  hpe_pkg::hpe_tok_type                     tok_in,
   output hpe_pkg::hpe_tok_type                     tok_out
);
   import hpe_pkg::*;

   logic                     mul_valid_ff;
   logic                     mul_sat_ff;
   logic signed [WIDE_W-1:0] prod_ff;
   logic signed [WIDE_W-1:0] prod_in;

   logic                     add_valid_ff;
   logic                     add_sat_ff;
   logic                     add_sat_in;
   logic signed [DATA_W-1:0] add_value_ff;
   logic signed [DATA_W-1:0] add_value_in;

   logic signed [WIDE_W-1:0] shifted;
   logic signed [WIDE_W-1:0] sum;

   assign prod_in = WIDE_W'(tok_in.value) * WIDE_W'(x_value);
   assign shifted = prod_ff >>> FRAC_BITS;
   assign sum     = shifted + {{DATA_W{coef[DATA_W-1]}}, coef};

   always_comb begin
      add_sat_in   = mul_sat_ff;
      add_value_in = sum[DATA_W-1:0];
      if (sum > WIDE_MAX) begin
         add_sat_in   = 1'b1;
         add_value_in = WIDE_MAX[DATA_W-1:0];
      end else if (sum < WIDE_MIN) begin
         add_sat_in   = 1'b1;
         add_value_in = WIDE_MIN[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         add_valid_ff <= 1'b0;
      end else if (adv) begin
         mul_valid_ff <= tok_in.valid;
         add_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_sat_ff   <= tok_in.sat;
         prod_ff      <= prod_in;
         add_sat_ff   <= add_sat_in;
         add_value_ff <= add_value_in;
      end
   end

   assign tok_out.valid = add_valid_ff;
   assign tok_out.sat   = add_sat_ff;
   assign tok_out.value = add_value_ff;

endmodule

// ===== rtl/horner_polynomial_evaluator_unit.sv =====
// Top level of the Horner polynomial evaluator: coefficient registers, head
// register, chain of hpe_cell steps and the result register. Depends on hpe_pkg.
//
// Usage:
//   Write coef_count (index 0) and coef_0..coef_6 (indices 1..7, leading
//   first) on the csr_ port while the block is idle. Each point transferred on
//   the req_ channel yields n results on the rsp_ channel, n being coef_count
//   (zero reads as one, values above MAX_COEFS as MAX_COEFS): partial k is
//   r_k = r_(k-1) * x + c_k in Q16.16, saturated, with r_0 = c_0.
//   Timing: a point enters a head register, then walks a row of cells, each
//   holding it first in its multiplier register and then in its adder
//   register. Each partial result goes from the register holding it into the
//   rsp_ register, the first one from the head register. A point occupies
//   the chain alone: req_stall stays high from the transfer until the last
//   result has entered the rsp_ register; the next point may then be taken
//   while that result still waits.
//   When rsp_stall is high with a result held, the whole chain freezes and
//   the held result stays on the rsp_ ports.
//   Reset (synchronous) drops any point in flight, sets coef_count to one and
//   clears the coefficients to zero.
`timescale 1ns / 1ps

module horner_polynomial_evaluator_unit #(
   parameter int MAX_COEFS = hpe_pkg::DEF_MAX_COEFS,
   parameter int FRAC_BITS = hpe_pkg::DEF_FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   csr_wen,
   input  logic [hpe_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [hpe_pkg::DATA_W-1:0]             csr_wdata,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [hpe_pkg::DATA_W-1:0]      req_x_value,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [hpe_pkg::DATA_W-1:0]      rsp_partial_value,
   output logic [hpe_pkg::COUNT_W-1:0]            rsp_partial_index,
   output logic                                   rsp_is_last,
   output logic                                   rsp_saturated
);
   import hpe_pkg::*;

   logic [COUNT_W-1:0]       coef_count_ff;
   logic signed [DATA_W-1:0] coef_ff [MAX_COEFS];

   logic [COUNT_W-1:0]       count_eff;
   logic [COUNT_W-1:0]       last_index;

   logic                     busy_ff;
   logic signed [DATA_W-1:0] x_ff;
   logic                     head_valid_ff;
   logic signed [DATA_W-1:0] head_value_ff;

   hpe_tok_type              tok [MAX_COEFS];
   hpe_tok_type              cell_in [1:MAX_COEFS-1];
   logic [MAX_COEFS-1:0]     tok_valid;

   logic                     adv;
   logic                     req_xfer;
   logic                     emit_valid;
   logic                     emit_sat;
   logic signed [DATA_W-1:0] emit_value;
   logic [COUNT_W-1:0]       emit_index;
   logic                     emit_last;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic [COUNT_W-1:0]       rsp_index_ff;
   logic                     rsp_last_ff;
   logic                     rsp_sat_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_count_ff <= COUNT_RESET;
         for (int i = 0; i < MAX_COEFS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_wen) begin
         if (csr_index == REG_COEF_COUNT) begin
            coef_count_ff <= csr_wdata[COUNT_W-1:0];
         end
         for (int i = 0; i < MAX_COEFS; i++) begin
            if (csr_index == REG_COEF_BASE + CSR_INDEX_W'(i)) begin
               coef_ff[i] <= csr_wdata;
            end
         end
      end
   end

   always_comb begin
      if (coef_count_ff == '0) begin
         count_eff = COUNT_W'(1);
      end else if (coef_count_ff > COUNT_W'(MAX_COEFS)) begin
         count_eff = COUNT_W'(MAX_COEFS);
      end else begin
         count_eff = coef_count_ff;
      end
   end

   assign last_index = count_eff - COUNT_W'(1);

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = busy_ff;
   assign req_xfer  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         head_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            busy_ff <= 1'b1;
         end else if (adv && emit_valid && emit_last) begin
            busy_ff <= 1'b0;
         end
         if (req_xfer) begin
            head_valid_ff <= 1'b1;
         end else if (adv) begin
            head_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         x_ff          <= req_x_value;
         head_value_ff <= coef_ff[0];
      end
   end

   // chain of cells
   assign tok[0].valid = head_valid_ff;
   assign tok[0].sat   = 1'b0;
   assign tok[0].value = head_value_ff;

   for (genvar k = 1; k < MAX_COEFS; k++) begin : g_cell
      assign cell_in[k].valid = tok[k-1].valid && (COUNT_W'(k - 1) != last_index);
      assign cell_in[k].sat   = tok[k-1].sat;
      assign cell_in[k].value = tok[k-1].value;

      hpe_cell #(
         .FRAC_BITS(FRAC_BITS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .x_value(x_ff),
         .coef   (coef_ff[k]),
         .tok_in (cell_in[k]),
         .tok_out(tok[k])
      );
   end

   always_comb begin
      emit_valid = 1'b0;
      emit_sat   = 1'b0;
      emit_value = tok[0].value;
      emit_index = '0;
      for (int k = 0; k < MAX_COEFS; k++) begin
         tok_valid[k] = tok[k].valid;
         if (tok[k].valid) begin
            emit_valid = 1'b1;
            emit_sat   = tok[k].sat;
            emit_value = tok[k].value;
            emit_index = COUNT_W'(k);
         end
      end
   end

   assign emit_last = (emit_index == last_index);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_value_ff <= emit_value;
         rsp_index_ff <= emit_index;
         rsp_last_ff  <= emit_last;
         rsp_sat_ff   <= emit_sat;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_partial_value = rsp_value_ff;
   assign rsp_partial_index = rsp_index_ff;
   assign rsp_is_last       = rsp_last_ff;
   assign rsp_saturated     = rsp_sat_ff;

   // checks
   a_single_point : assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid))
      else $error("more than one partial result in the chain");

   a_idle_empty : assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (tok_valid == '0))
      else $error("chain holds a partial result while idle");

   a_head_load : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> tok_valid[0])
      else $error("transferred point did not enter the head register");

endmodule
